### design/rpwl_pkg.sv
package rpwl_pkg;

    // Command codes carried in the mode field.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_COMMIT = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Value of every byte of a page that has never been programmed.
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] container_index;
        logic [3:0] byte_offset;
        logic [7:0] data_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic [2:0] page_slot;
        logic       last;
    } result_t;

endpackage

### design/rotating_page_wear_leveler.sv
// Rotating page wear leveler.
// A command transfer is accepted on a rising clock edge where start is high and
// busy is low. The cmd struct selects one of four modes. Loading a staging byte
// and clearing the staging buffer finish in the accept cycle and give no result,
// so busy never rises for them.
// A commit copies the latest page into the first unused page, byte by byte,
// with the staging buffer placed in the chosen container slot. The copy runs
// through the single read and write port of the page memory, one byte per
// cycle, so busy stays high until the one result transfer, which appears
// as busy falls.
// A read streams one container of the latest page: CONTAINER_BYTES result
// transfers on consecutive cycles, the first after the issue, memory read
// and result registers, with busy falling as the final one appears. The read
// bytes also refill the staging buffer.
// Each result transfer is valid for exactly one cycle while strobe is high; the
// receiver cannot stall the block and must take it then.
// Reset returns the block to idle with every page unused and erased and the
// staging buffer zero. Erased state is kept as one valid bit per page and per
// staging byte, so no clearing pass is needed after reset.
module rotating_page_wear_leveler #(
    parameter int PAGES               = 8,
    parameter int CONTAINERS_PER_PAGE = 4,
    parameter int CONTAINER_BYTES     = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rpwl_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              strobe,
    output rpwl_pkg::result_t result
);

    import rpwl_pkg::*;

    localparam int PAGE_BYTES  = CONTAINERS_PER_PAGE * CONTAINER_BYTES;
    localparam int STORE_BYTES = PAGES * PAGE_BYTES;
    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int JW  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int BIW = (CONTAINER_BYTES > 1) ? $clog2(CONTAINER_BYTES) : 1;
    localparam int CIW = (CONTAINERS_PER_PAGE > 1) ? $clog2(CONTAINERS_PER_PAGE) : 1;
    localparam int PW  = $clog2(PAGES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_READ
    } state_t;

    state_t                 state_reg, state_next;
    logic [JW-1:0]          cnt_reg, cnt_next;
    logic [BIW-1:0]         b_reg, b_next;
    logic [CIW-1:0]         c_reg, c_next;
    logic                   issue_reg, issue_next;
    logic [AW-1:0]          base_reg, base_next;
    logic [AW-1:0]          dbase_reg, dbase_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   idx_ok_reg, idx_ok_next;
    logic                   src_ok_reg, src_ok_next;
    logic [PW-1:0]          slot_reg, slot_next;
    logic                   pv_reg, pv_next;
    logic                   plast_reg, plast_next;
    logic                   pbuf_reg, pbuf_next;
    logic [AW-1:0]          pwaddr_reg, pwaddr_next;
    logic [BIW-1:0]         pboff_reg, pboff_next;
    logic                   sbq_ok_reg, sbq_ok_next;
    logic [PW-1:0]          tgt_reg, tgt_next;
    logic [PAGES-1:0]       page_valid_reg, page_valid_next;
    logic [CONTAINER_BYTES-1:0] sb_valid_reg, sb_valid_next;
    logic                   strobe_reg, strobe_next;
    result_t                result_reg, result_next;

    logic                   accept;
    logic [PW-1:0]          src_page;
    logic                   cmd_idx_ok;
    logic                   last_issue;

    logic                   pg_we, pg_re;
    logic [AW-1:0]          pg_waddr, pg_raddr;
    logic [7:0]             pg_wdata, pg_q, pg_data;
    logic                   sb_we, sb_re;
    logic [BIW-1:0]         sb_waddr;
    logic [7:0]             sb_wdata, sb_q, sb_data;
    logic                   load_we;

    // The source is the page just before the target, wrapping to the last page.
    assign accept     = start && (state_reg == S_IDLE);
    assign src_page   = (tgt_reg == '0) ? PW'(PAGES - 1) : tgt_reg - PW'(1);
    assign cmd_idx_ok = 32'(cmd.container_index) < CONTAINERS_PER_PAGE;
    assign last_issue = (state_reg == S_COPY) ? (cnt_reg == JW'(PAGE_BYTES - 1))
                                              : (b_reg == BIW'(CONTAINER_BYTES - 1));

    // Pages and staging bytes that were never written read as their reset value.
    assign pg_data = src_ok_reg ? pg_q : ERASED_BYTE;
    assign sb_data = sbq_ok_reg ? sb_q : 8'h00;

    assign pg_re    = issue_reg && ((state_reg == S_COPY) || idx_ok_reg);
    assign pg_raddr = base_reg + AW'(cnt_reg);
    assign pg_we    = pv_reg && (state_reg == S_COPY);
    assign pg_waddr = pwaddr_reg;
    assign pg_wdata = pbuf_reg ? sb_data : pg_data;

    assign sb_re    = issue_reg && (state_reg == S_COPY);
    assign load_we  = accept && (cmd.mode == MODE_LOAD)
                      && (32'(cmd.byte_offset) < CONTAINER_BYTES);
    assign sb_we    = load_we || (pv_reg && (state_reg == S_READ) && idx_ok_reg);
    assign sb_waddr = load_we ? BIW'(cmd.byte_offset) : pboff_reg;
    assign sb_wdata = load_we ? cmd.data_in : pg_data;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        issue_next      = issue_reg;
        base_next       = base_reg;
        dbase_next      = dbase_reg;
        idx_next        = idx_reg;
        idx_ok_next     = idx_ok_reg;
        src_ok_next     = src_ok_reg;
        slot_next       = slot_reg;
        pv_next         = 1'b0;
        plast_next      = plast_reg;
        pbuf_next       = pbuf_reg;
        pwaddr_next     = pwaddr_reg;
        pboff_next      = pboff_reg;
        sbq_ok_next     = sbq_ok_reg;
        tgt_next        = tgt_reg;
        page_valid_next = page_valid_reg;
        sb_valid_next   = sb_valid_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;

        if (accept)
        begin
            cnt_next    = '0;
            b_next      = '0;
            c_next      = '0;
            idx_next    = cmd.container_index;
            idx_ok_next = cmd_idx_ok;
            src_ok_next = page_valid_reg[src_page];
            case (cmd.mode)
                MODE_COMMIT:
                begin
                    state_next = S_COPY;
                    issue_next = 1'b1;
                    base_next  = AW'(32'(src_page) * PAGE_BYTES);
                    dbase_next = AW'(32'(tgt_reg) * PAGE_BYTES);
                    slot_next  = tgt_reg;
                end
                MODE_READ:
                begin
                    state_next = S_READ;
                    issue_next = 1'b1;
                    base_next  = AW'(32'(src_page) * PAGE_BYTES
                                     + 32'(cmd.container_index) * CONTAINER_BYTES);
                    slot_next  = src_page;
                end
                MODE_CLEAR:
                begin
                    sb_valid_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        // Issue stage: one memory read per cycle through the shared address adder.
        if (issue_reg)
        begin
            pv_next     = 1'b1;
            plast_next  = last_issue;
            issue_next  = !last_issue;
            pwaddr_next = dbase_reg + AW'(cnt_reg);
            pboff_next  = b_reg;
            pbuf_next   = 32'(c_reg) == 32'(idx_reg);
            sbq_ok_next = sb_valid_reg[b_reg];
            cnt_next    = cnt_reg + JW'(1);
            if (b_reg == BIW'(CONTAINER_BYTES - 1))
            begin
                b_next = '0;
                c_next = c_reg + CIW'(1);
            end
            else
            begin
                b_next = b_reg + BIW'(1);
            end
        end

        if (sb_we)
        begin
            sb_valid_next[sb_waddr] = 1'b1;
        end

        // Completion stage: the byte read in the previous cycle is written or sent.
        if (pv_reg)
        begin
            if (state_reg == S_READ)
            begin
                strobe_next          = 1'b1;
                result_next.data_out = idx_ok_reg ? pg_data : 8'h00;
                result_next.page_slot = 3'(slot_reg);
                result_next.last     = plast_reg;
            end
            else if (plast_reg)
            begin
                strobe_next           = 1'b1;
                result_next.data_out  = 8'h00;
                result_next.page_slot = 3'(slot_reg);
                result_next.last      = 1'b1;
                page_valid_next[tgt_reg] = 1'b1;
                if (idx_ok_reg)
                begin
                    // A commit with a valid index moves the target on, wrapping to page 0.
                    tgt_next = (tgt_reg == PW'(PAGES - 1)) ? '0 : tgt_reg + PW'(1);
                end
            end
            if (plast_reg)
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            issue_reg      <= 1'b0;
            base_reg       <= '0;
            dbase_reg      <= '0;
            idx_reg        <= '0;
            idx_ok_reg     <= 1'b0;
            src_ok_reg     <= 1'b0;
            slot_reg       <= '0;
            pv_reg         <= 1'b0;
            plast_reg      <= 1'b0;
            pbuf_reg       <= 1'b0;
            pwaddr_reg     <= '0;
            pboff_reg      <= '0;
            sbq_ok_reg     <= 1'b0;
            tgt_reg        <= '0;
            page_valid_reg <= '0;
            sb_valid_reg   <= '0;
            strobe_reg     <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            b_reg          <= b_next;
            c_reg          <= c_next;
            issue_reg      <= issue_next;
            base_reg       <= base_next;
            dbase_reg      <= dbase_next;
            idx_reg        <= idx_next;
            idx_ok_reg     <= idx_ok_next;
            src_ok_reg     <= src_ok_next;
            slot_reg       <= slot_next;
            pv_reg         <= pv_next;
            plast_reg      <= plast_next;
            pbuf_reg       <= pbuf_next;
            pwaddr_reg     <= pwaddr_next;
            pboff_reg      <= pboff_next;
            sbq_ok_reg     <= sbq_ok_next;
            tgt_reg        <= tgt_next;
            page_valid_reg <= page_valid_next;
            sb_valid_reg   <= sb_valid_next;
            strobe_reg     <= strobe_next;
            result_reg     <= result_next;
        end
    end

    rpwl_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_page_ram (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .re    (pg_re),
        .raddr (pg_raddr),
        .rdata (pg_q)
    );

    rpwl_ram #(
        .DEPTH (CONTAINER_BYTES),
        .AW    (BIW)
    ) u_stage_ram (
        .clk   (clk),
        .we    (sb_we),
        .waddr (sb_waddr),
        .wdata (sb_wdata),
        .re    (sb_re),
        .raddr (b_reg),
        .rdata (sb_q)
    );

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Every result transfer closes out work that held the block busy.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result transfer without a command in progress");

    // A read stream has no gaps until its final transfer.
    a_stream_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("gap in read result stream");

    // The final transfer of a command finds the block ready again.
    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> !busy)
        else $error("block still busy at final transfer");

    // Staging loads and clears finish in the accept cycle.
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.mode == MODE_LOAD || cmd.mode == MODE_CLEAR)
        |=> !busy && !strobe)
        else $error("staging command made the block busy");
`endif

endmodule

### design/rpwl_ram.sv
module rpwl_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### tb/wear_leveler_checker.sv
`timescale 1ns / 100ps

module wear_leveler_checker #(
    parameter int PAGES               = 8,
    parameter int CONTAINERS_PER_PAGE = 4,
    parameter int CONTAINER_BYTES     = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rpwl_pkg::cmd_t    cmd,
    input  logic              busy,
    input  logic              strobe,
    input  rpwl_pkg::result_t result,
    output int unsigned       mismatches,
    output int unsigned       outstanding
);
    import rpwl_pkg::*;

    localparam int PAGE_BYTES   = CONTAINERS_PER_PAGE * CONTAINER_BYTES;
    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the page memory, the page header and the staging buffer.
    logic [7:0]       shadow_store [0:PAGES*PAGE_BYTES-1];
    logic [PAGES-1:0] unused_marks;
    logic [7:0]       shadow_staging [0:CONTAINER_BYTES-1];

    result_t     due_results [$];
    int unsigned fail_count = 0;

    function automatic int unsigned first_unused_page();
        for (int p = 0; p < PAGES; p++)
        begin
            if (unused_marks[p])
                return p;
        end
        return 0;
    endfunction

    // Updates the shadow state for one accepted command and queues the
    // result transfers that it must produce.
    task automatic apply_command(input cmd_t c);
        int unsigned target;
        int unsigned source;
        int unsigned dst;
        int unsigned src;
        logic [7:0]  value;
        result_t     r;
        case (c.mode)
            MODE_LOAD:
            begin
                if (c.byte_offset < CONTAINER_BYTES)
                    shadow_staging[c.byte_offset] = c.data_in;
            end
            MODE_CLEAR:
            begin
                for (int b = 0; b < CONTAINER_BYTES; b++)
                    shadow_staging[b] = 8'h00;
            end
            default:
            begin
                target = first_unused_page();
                source = (target == 0) ? PAGES - 1 : target - 1;
                if (c.mode == MODE_COMMIT)
                begin
                    for (int k = 0; k < CONTAINERS_PER_PAGE; k++)
                    begin
                        for (int b = 0; b < CONTAINER_BYTES; b++)
                        begin
                            dst = target * PAGE_BYTES + k * CONTAINER_BYTES + b;
                            src = source * PAGE_BYTES + k * CONTAINER_BYTES + b;
                            if (k == c.container_index)
                                shadow_store[dst] = shadow_staging[b];
                            else
                                shadow_store[dst] = shadow_store[src];
                        end
                    end
                    if (c.container_index < CONTAINERS_PER_PAGE)
                    begin
                        if (target == PAGES - 1)
                            unused_marks = '1;
                        else
                            unused_marks[target] = 1'b0;
                    end
                    r.data_out  = 8'h00;
                    r.page_slot = 3'(target);
                    r.last      = 1'b1;
                    due_results.push_back(r);
                end
                else
                begin
                    for (int b = 0; b < CONTAINER_BYTES; b++)
                    begin
                        value = 8'h00;
                        if (c.container_index < CONTAINERS_PER_PAGE)
                        begin
                            src = source * PAGE_BYTES + c.container_index * CONTAINER_BYTES + b;
                            value = shadow_store[src];
                            shadow_staging[b] = value;
                        end
                        r.data_out  = value;
                        r.page_slot = 3'(source);
                        r.last      = (b == CONTAINER_BYTES - 1);
                        due_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: result with nothing expected: data_out=%02h page_slot=%0d last=%0b",
                         $time, got.data_out, got.page_slot, got.last);
        end
        else
        begin
            want = due_results.pop_front();
            if (got.data_out !== want.data_out || got.page_slot !== want.page_slot ||
                got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: mismatch: expected data_out=%02h page_slot=%0d last=%0b, got data_out=%02h page_slot=%0d last=%0b",
                             $time, want.data_out, want.page_slot, want.last,
                             got.data_out, got.page_slot, got.last);
            end
        end
    endtask

    // Results are checked before a command accepted at the same edge is
    // predicted, since that command's results can only come later.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGES * PAGE_BYTES; i++)
                shadow_store[i] = ERASED_BYTE;
            for (int b = 0; b < CONTAINER_BYTES; b++)
                shadow_staging[b] = 8'h00;
            unused_marks = '1;
            due_results.delete();
            mismatches  <= fail_count;
            outstanding <= 0;
        end
        else
        begin
            if (strobe)
                check_result(result);
            if (start && !busy)
                apply_command(cmd);
            mismatches  <= fail_count;
            outstanding <= due_results.size();
        end
    end

endmodule

### tb/tb_rotating_page_wear_leveler.sv
`timescale 1ns / 100ps

// Testbench top for the rotating page wear leveler. This module only makes
// stimulus and gives the verdict; the checker beside the block watches both
// channels, predicts every result transfer and compares them.
module tb_rotating_page_wear_leveler;
    import rpwl_pkg::*;

    localparam int PAGES               = 8;
    localparam int CONTAINERS_PER_PAGE = 4;
    localparam int CONTAINER_BYTES     = 16;
    localparam int PAGE_BYTES          = CONTAINERS_PER_PAGE * CONTAINER_BYTES;

    // Number of random command transfers after the directed part.
    localparam int RANDOM_ITEMS = 250;
    // Set far above what a correct run needs even if every command were a
    // full page commit preceded by the longest gap.
    localparam int CYCLE_LIMIT  = 400000;

    logic    clk;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    strobe;
    result_t result;

    int unsigned mismatches;
    int unsigned outstanding;

    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on     = 1'b1;

    rotating_page_wear_leveler #(
        .PAGES               (PAGES),
        .CONTAINERS_PER_PAGE (CONTAINERS_PER_PAGE),
        .CONTAINER_BYTES     (CONTAINER_BYTES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    wear_leveler_checker #(
        .PAGES               (PAGES),
        .CONTAINERS_PER_PAGE (CONTAINERS_PER_PAGE),
        .CONTAINER_BYTES     (CONTAINER_BYTES)
    ) leveler_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .strobe      (strobe),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Presents one command and holds it until the block takes the transfer.
    // The values read right after the edge are the ones the block saw, so the
    // loop ends on exactly the accepting edge. Now and then the sender then
    // drops start for a random gap, which lands on random phases of a commit
    // or a read stream as well as between back-to-back loads.
    task automatic send(input logic [1:0] mode, input logic [1:0] idx,
                        input logic [3:0] offset, input logic [7:0] din);
        cmd_t        c;
        int unsigned gap;
        c.mode            = mode;
        c.container_index = idx;
        c.byte_offset     = offset;
        c.data_in         = din;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (gaps_on && $urandom_range(99) < 6)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted result has been seen. The
    // checker publishes its count with a nonblocking update, so the first
    // look comes at the edge after the last accepted transfer.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Typical use of the store: stage a container (from a read, from a clear,
    // or on top of what is already staged), patch some bytes, commit it.
    task automatic record_update();
        logic [1:0]  slot;
        int unsigned count;
        slot = 2'($urandom_range(3));
        case ($urandom_range(2))
            0:       send(MODE_READ, slot, 4'($urandom_range(15)), 8'($urandom_range(255)));
            1:       send(MODE_CLEAR, 2'($urandom_range(3)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            default: ;
        endcase
        if ($urandom_range(9) == 0)
        begin
            for (int b = 0; b < CONTAINER_BYTES; b++)
                send(MODE_LOAD, 2'($urandom_range(3)), 4'(b), 8'($urandom_range(255)));
        end
        else
        begin
            count = $urandom_range(1, 5);
            repeat (count)
                send(MODE_LOAD, 2'($urandom_range(3)), 4'($urandom_range(15)),
                     8'($urandom_range(255)));
        end
        send(MODE_COMMIT, slot, 4'($urandom_range(15)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        int unsigned directed_count;
        int unsigned quiet_from;
        bit          mid_drain_done;

        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A read straight after reset comes from the last
        // page, which is still erased, and fills the staging buffer with
        // erased bytes.
        send(MODE_READ, 2'd0, 4'd9, 8'h3C);
        send(MODE_CLEAR, 2'd3, 4'd15, 8'hFF);
        // Lowest and highest buffer offsets with the extreme data values.
        send(MODE_LOAD, 2'd0, 4'd0, 8'h00);
        send(MODE_LOAD, 2'd3, 4'd15, 8'hFF);
        send(MODE_LOAD, 2'd1, 4'd7, 8'hA5);
        // First commit goes to page 0 and copies the last page around it.
        send(MODE_COMMIT, 2'd0, 4'd0, 8'h00);
        send(MODE_READ, 2'd0, 4'd15, 8'hFF);
        send(MODE_READ, 2'd3, 4'd0, 8'h00);
        send(MODE_LOAD, 2'd2, 4'd3, 8'h5A);
        send(MODE_COMMIT, 2'd3, 4'd15, 8'hFF);
        // Commit through the remaining pages; the one into the last page
        // sets every unused mark again.
        for (int p = 2; p < PAGES; p++)
            send(MODE_COMMIT, 2'(p), 4'(p), 8'(p * 37));
        // After the wrap the target is page 0 again and the source the last.
        send(MODE_COMMIT, 2'd1, 4'd8, 8'h81);
        send(MODE_READ, 2'd1, 4'd1, 8'h7E);
        send(MODE_CLEAR, 2'd0, 4'd0, 8'h00);
        send(MODE_COMMIT, 2'd2, 4'd4, 8'h42);
        send(MODE_READ, 2'd2, 4'd12, 8'hC3);
        drain();

        // Random part: mostly read-modify-commit sequences, the rest single
        // commands of any kind. A stretch in the middle runs with no sender
        // gaps, and once halfway through the sender waits for the block to
        // go completely quiet.
        directed_count = items_sent;
        quiet_from     = directed_count + RANDOM_ITEMS / 3;
        mid_drain_done = 1'b0;
        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            gaps_on = (items_sent < quiet_from) || (items_sent >= quiet_from + 70);
            if (!mid_drain_done && items_sent >= directed_count + RANDOM_ITEMS / 2)
            begin
                drain();
                mid_drain_done = 1'b1;
            end
            if ($urandom_range(99) < 70)
                record_update();
            else
                send(2'($urandom_range(3)), 2'($urandom_range(3)),
                     4'($urandom_range(15)), 8'($urandom_range(255)));
        end

        // Let every result arrive, then wait longer than one page copy to show any
        // stray transfer.
        drain();
        repeat (PAGE_BYTES + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
